@@ hdl/glct_pkg.sv @@
// Shared types and constants of the grid line cell tracer.
// Used by the front classifier, the back stepper and the top level.
`default_nettype none

package glct_pkg;

  localparam int COORD_W = 6;
  // Error term: holds values between minus half and plus half the major delta.
  localparam int ERR_W   = COORD_W + 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // One classified line, ready for the stepper.
  typedef struct packed {
    logic   steep;      // y is the major axis
    logic   skip_first; // ends were swapped: first visited cell is the end cell
    logic   neg;        // minor coordinate steps downward
    coord_t a_start;    // major coordinate of the first visited cell
    coord_t a_stop;     // major coordinate of the last emitted cell
    coord_t b_start;    // minor coordinate of the first visited cell
    coord_t dmaj;
    coord_t dmin;
  } job_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } cell_t;

  typedef struct packed {
    logic idle;
  } back_stat_t;

endpackage

`default_nettype wire

@@ hdl/glct_fifo.sv @@
// Two-entry register queue of generic width.
// Standalone; used for the job queue and the result queue.
`default_nettype none

module glct_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/glct_front.sv @@
// Front classifier: range check, major axis choice and end swap of a request.
// Depends on glct_pkg; feeds the job queue.
`default_nettype none

module glct_front #(
  parameter int GRID_SIDE = 64
) (
  input  wire logic              req_valid,
  input  wire glct_pkg::coord_t  start_x,
  input  wire glct_pkg::coord_t  start_y,
  input  wire glct_pkg::coord_t  end_x,
  input  wire glct_pkg::coord_t  end_y,
  input  wire logic              job_full,
  output logic                   req_full,
  output logic                   job_push,
  output glct_pkg::job_t         job
);

  localparam logic [glct_pkg::COORD_W:0] SIDE = (glct_pkg::COORD_W+1)'(GRID_SIDE);

  glct_pkg::coord_t adx, ady;
  glct_pkg::coord_t s_maj, s_min, e_maj, e_min;
  glct_pkg::coord_t a0, a1, b0, b1;
  logic             steep, swap, in_grid;

  always_comb begin
    adx   = (end_x > start_x) ? end_x - start_x : start_x - end_x;
    ady   = (end_y > start_y) ? end_y - start_y : start_y - end_y;
    steep = ady > adx;
    s_maj = steep ? start_y : start_x;
    s_min = steep ? start_x : start_y;
    e_maj = steep ? end_y : end_x;
    e_min = steep ? end_x : end_y;
    // Swap so that the major coordinate ascends.
    swap  = s_maj > e_maj;
    a0    = swap ? e_maj : s_maj;
    a1    = swap ? s_maj : e_maj;
    b0    = swap ? e_min : s_min;
    b1    = swap ? s_min : e_min;

    in_grid = ({1'b0, start_x} < SIDE) && ({1'b0, start_y} < SIDE) &&
              ({1'b0, end_x} < SIDE) && ({1'b0, end_y} < SIDE);

    job.steep      = steep;
    job.skip_first = swap;
    job.neg        = !(b0 < b1);
    job.a_start    = a0;
    // Without a swap the end cell is the final one visited: stop one short.
    job.a_stop     = swap ? a1 : a1 - glct_pkg::COORD_W'(1);
    job.b_start    = b0;
    job.dmaj       = a1 - a0;
    job.dmin       = (b1 > b0) ? b1 - b0 : b0 - b1;
  end

  assign req_full = job_full;
  // Drop requests outside the grid and zero-length lines.
  assign job_push = req_valid && !job_full && in_grid && (job.dmaj != '0);

endmodule

`default_nettype wire

@@ hdl/glct_back.sv @@
// Back stepper: walks one classified line a cell per cycle, while the result queue has room, with the error term.
// Depends on glct_pkg; pops the job queue and pushes the result queue.
`default_nettype none

module glct_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_empty,
  input  wire glct_pkg::job_t  job,
  output logic                 job_pop,
  input  wire logic            cell_full,
  output logic                 cell_push,
  output glct_pkg::cell_t      step_cell,
  output glct_pkg::back_stat_t status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic             steep_r, skip_r, neg_r;
  glct_pkg::coord_t a_r, a_stop_r, b_r, dmaj_r, dmin_r;
  glct_pkg::err_t   err_r, err_add;
  logic             step_minor, is_last, advance;
  glct_pkg::coord_t b_step;

  always_comb begin
    err_add    = err_r + $signed({2'b00, dmin_r});
    step_minor = $signed({err_add, 1'b0}) >= $signed({3'b000, dmaj_r});
    b_step     = neg_r ? b_r - glct_pkg::COORD_W'(1) : b_r + glct_pkg::COORD_W'(1);
    is_last    = (a_r == a_stop_r);
    advance    = (state_r == ST_RUN) && (skip_r || !cell_full);
  end

  assign job_pop        = (state_r == ST_IDLE) && !job_empty;
  assign cell_push      = (state_r == ST_RUN) && !skip_r && !cell_full;
  assign step_cell.x    = steep_r ? b_r : a_r;
  assign step_cell.y    = steep_r ? a_r : b_r;
  assign step_cell.last = is_last;
  assign status.idle    = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_pop) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cell_push && is_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      steep_r  <= job.steep;
      skip_r   <= job.skip_first;
      neg_r    <= job.neg;
      a_r      <= job.a_start;
      a_stop_r <= job.a_stop;
      b_r      <= job.b_start;
      dmaj_r   <= job.dmaj;
      dmin_r   <= job.dmin;
      err_r    <= '0;
    end else if (advance) begin
      // Minor coordinate moves only after the current cell is taken or skipped.
      skip_r <= 1'b0;
      a_r    <= a_r + glct_pkg::COORD_W'(1);
      if (step_minor) begin
        b_r   <= b_step;
        err_r <= err_add - $signed({2'b00, dmaj_r});
      end else begin
        err_r <= err_add;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/grid_line_cell_tracer_top.sv @@
// Grid line cell tracer: a request names a start and an end cell; the block
// returns the Bresenham cells between start and end in ascending major
// coordinate, leaving out the end cell, with last on the final cell. Requests
// with a coordinate outside the grid, or with start equal to end, give no
// result. The front takes one request per cycle while its two-entry job queue
// has room; the back stepper first loads a job, then walks its cells in
// order, emitting max(|dx|,|dy|) cells, and first visits and skips the end cell
// when it lies at the low end of the major axis. Requests are walked one at a
// time by the single stepper, while the front queues new ones. Results wait in
// a two-entry queue, so the stepper stalls only while that queue is full.
`default_nettype none

module grid_line_cell_tracer_top #(
  parameter int GRID_SIDE = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [glct_pkg::COORD_W-1:0] in_start_x,
  input  wire logic [glct_pkg::COORD_W-1:0] in_start_y,
  input  wire logic [glct_pkg::COORD_W-1:0] in_end_x,
  input  wire logic [glct_pkg::COORD_W-1:0] in_end_y,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [glct_pkg::COORD_W-1:0] out_cell_x,
  output logic [glct_pkg::COORD_W-1:0] out_cell_y,
  output logic                        out_last
);

  localparam int JOB_W  = $bits(glct_pkg::job_t);
  localparam int CELL_W = $bits(glct_pkg::cell_t);

  glct_pkg::job_t       job_in, job_out;
  logic [JOB_W-1:0]     job_in_bits, job_out_bits;
  logic                 job_push, job_full, job_pop, job_empty;
  glct_pkg::cell_t      cell_in, cell_out;
  logic [CELL_W-1:0]    cell_in_bits, cell_out_bits;
  logic                 cell_push, cell_full;
  glct_pkg::back_stat_t back_stat;

  glct_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .req_valid (push),
    .start_x   (in_start_x),
    .start_y   (in_start_y),
    .end_x     (in_end_x),
    .end_y     (in_end_y),
    .job_full  (job_full),
    .req_full  (full),
    .job_push  (job_push),
    .job       (job_in)
  );

  assign job_in_bits = job_in;

  glct_fifo #(
    .WIDTH (JOB_W)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_in_bits),
    .full    (job_full),
    .pop     (job_pop),
    .rd_data (job_out_bits),
    .empty   (job_empty)
  );

  assign job_out = job_out_bits;

  glct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .cell_full (cell_full),
    .cell_push (cell_push),
    .step_cell (cell_in),
    .status    (back_stat)
  );

  assign cell_in_bits = cell_in;

  glct_fifo #(
    .WIDTH (CELL_W)
  ) u_cell_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cell_push),
    .wr_data (cell_in_bits),
    .full    (cell_full),
    .pop     (pop),
    .rd_data (cell_out_bits),
    .empty   (empty)
  );

  assign cell_out   = cell_out_bits;
  assign out_cell_x = cell_out.x;
  assign out_cell_y = cell_out.y;
  assign out_last   = cell_out.last;

  // Result queue comes out of reset empty.
  assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // The stepper returns to idle right after the final cell of a line.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cell_push && cell_in.last) |=> back_stat.idle)
    else $error("stepper still busy after last cell");

  // Every emitted cell lies inside the grid.
  assert property (@(posedge clk) disable iff (!rst_n)
    cell_push |-> (({1'b0, cell_in.x} < (glct_pkg::COORD_W+1)'(GRID_SIDE)) &&
                   ({1'b0, cell_in.y} < (glct_pkg::COORD_W+1)'(GRID_SIDE))))
    else $error("emitted cell outside the grid");

endmodule

`default_nettype wire
